FILE: rtl/pes_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// PES packet header parser package
// Shared types, phase codes, result codes and the result record.
// ============================================================================
package pes_pkg;

    typedef enum logic [3:0] {
        PH_PREFIX  = 4'd0,
        PH_PASS    = 4'd1,
        PH_M2HDR   = 4'd2,
        PH_M2DATA  = 4'd3,
        PH_M1STUFF = 4'd4,
        PH_M1STD   = 4'd5,
        PH_M1CODE  = 4'd6,
        PH_M1TS    = 4'd7,
        PH_M1DATA  = 4'd8
    } phase_t;

    localparam logic [1:0] RK_PAYLOAD = 2'd0;
    localparam logic [1:0] RK_SUMMARY = 2'd1;
    localparam logic [1:0] RK_ERROR   = 2'd2;

    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_START    = 4'd1;
    localparam logic [3:0] ERR_ID       = 4'd2;
    localparam logic [3:0] ERR_SHORT    = 4'd3;
    localparam logic [3:0] ERR_PASTEND  = 4'd4;
    localparam logic [3:0] ERR_FLAGS    = 4'd5;
    localparam logic [3:0] ERR_M1HDR    = 4'd6;
    localparam logic [3:0] ERR_TSCODE   = 4'd7;
    localparam logic [3:0] ERR_LENGTH   = 4'd8;

    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  data_value;
        logic [7:0]  stream_code;
        logic [32:0] pts_value;
        logic [32:0] dts_value;
        logic        pts_present;
        logic        dts_present;
        logic [12:0] header_flags;
        logic [7:0]  header_data_length;
        logic [3:0]  error_code;
        logic        last_of_packet;
    } result_t;

    function automatic logic [32:0] ts_of(input logic [39:0] s);
        ts_of = {s[35:33], s[31:24], s[23:17], s[15:8], s[7:1]};
    endfunction

endpackage

FILE: rtl/pes_front.sv
`timescale 1ns / 1ps
// ============================================================================
// PES parser front end
// Tracks the packet phase per byte and produces at most one result record
// for each accepted transaction.
// ============================================================================
module pes_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mpeg2_mode,
    input  logic                in_valid,
    input  logic                kind,
    input  logic [7:0]          in_byte,
    output logic                res_valid,
    output pes_pkg::result_t    res
);
    import pes_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [16:0] count_reg, count_next;
    logic [15:0] plen_reg, plen_next;
    logic [7:0]  sid_reg, sid_next;
    logic [12:0] flags_reg, flags_next;
    logic [7:0]  hlen_reg, hlen_next;
    logic [7:0]  hleft_reg, hleft_next;
    logic [39:0] pts_reg, pts_next;
    logic [39:0] dts_reg, dts_next;
    logic        done_reg, done_next;
    logic [1:0]  tsf_reg, tsf_next;

    logic        bounded, last, special, pass_id;
    logic [16:0] cnt1, end_cnt, rem;
    logic [4:0]  need;
    logic [16:0] off;
    logic [7:0]  hl_dec;
    logic [15:0] plen_full;
    logic        emit;
    logic        sum_p, sum_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            count_reg <= '0;
            plen_reg  <= '0;
            sid_reg   <= '0;
            flags_reg <= '0;
            hlen_reg  <= '0;
            hleft_reg <= '0;
            pts_reg   <= '0;
            dts_reg   <= '0;
            done_reg  <= 1'b0;
            tsf_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            plen_reg  <= plen_next;
            sid_reg   <= sid_next;
            flags_reg <= flags_next;
            hlen_reg  <= hlen_next;
            hleft_reg <= hleft_next;
            pts_reg   <= pts_next;
            dts_reg   <= dts_next;
            done_reg  <= done_next;
            tsf_reg   <= tsf_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        plen_next  = plen_reg;
        sid_next   = sid_reg;
        flags_next = flags_reg;
        hlen_next  = hlen_reg;
        hleft_next = hleft_reg;
        pts_next   = pts_reg;
        dts_next   = dts_reg;
        done_next  = done_reg;
        tsf_next   = tsf_reg;
        emit       = 1'b0;
        res        = '0;
        sum_p      = 1'b0;
        sum_d      = 1'b0;

        bounded = (plen_reg != 16'd0);
        cnt1    = (count_reg < COUNT_MAX) ? count_reg + 17'd1 : count_reg;
        end_cnt = 17'd6 + {1'b0, plen_reg};
        last    = (phase_reg != PH_PREFIX) && bounded && (cnt1 == end_cnt);
        rem     = end_cnt - count_reg;
        off     = count_reg - 17'd9;
        hl_dec  = hleft_reg - 8'd1;
        plen_full = {plen_reg[15:8], in_byte};
        special = (sid_reg == 8'hBF) || (sid_reg == 8'hBC) || (sid_reg == 8'hF0)
               || (sid_reg == 8'hF1) || (sid_reg == 8'hFF) || (sid_reg == 8'hF2)
               || (sid_reg == 8'hF8);
        pass_id = (sid_reg == 8'hBE) || special;
        need = '0;
        if (tsf_reg[1])
            need = tsf_reg[0] ? 5'd10 : 5'd5;
        if (!flags_reg[0])
            need = need + (flags_reg[5] ? 5'd6 : 5'd0) + (flags_reg[4] ? 5'd3 : 5'd0)
                 + {4'd0, flags_reg[3]} + {4'd0, flags_reg[2]}
                 + (flags_reg[1] ? 5'd2 : 5'd0);

        res.stream_code = sid_reg;

        if (in_valid && !done_reg)
        begin
            if (kind)
            begin
                emit = 1'b1;
                res.result_kind = RK_ERROR;
                res.last_of_packet = 1'b1;
                done_next = 1'b1;
                if (phase_reg == PH_PREFIX)
                    res.error_code = ERR_SHORT;
                else if (bounded)
                    res.error_code = ERR_LENGTH;
                else
                begin
                    unique case (phase_reg)
                        PH_PASS, PH_M1DATA: res.error_code = ERR_NONE;
                        PH_M2HDR:
                            res.error_code = (count_reg < 17'd9) ? ERR_SHORT : ERR_PASTEND;
                        PH_M2DATA:
                            res.error_code = (count_reg == 17'd9 + {9'd0, hlen_reg})
                                           ? ERR_PASTEND : ERR_NONE;
                        default: res.error_code = ERR_M1HDR;
                    endcase
                end
            end
            else
            begin
                count_next = cnt1;
                unique case (phase_reg)
                    PH_PREFIX:
                    begin
                        if (count_reg < 17'd2)
                        begin
                            if (in_byte != 8'h00)
                            begin
                                emit = 1'b1;
                                res.error_code = ERR_START;
                            end
                        end
                        else if (count_reg == 17'd2)
                        begin
                            if (in_byte != 8'h01)
                            begin
                                emit = 1'b1;
                                res.error_code = ERR_START;
                            end
                        end
                        else if (count_reg == 17'd3)
                            sid_next = in_byte;
                        else if (count_reg == 17'd4)
                            plen_next = {in_byte, 8'h00};
                        else
                        begin
                            plen_next = plen_full;
                            if (pass_id)
                            begin
                                if (!mpeg2_mode && sid_reg != 8'hBF && sid_reg != 8'hBE)
                                begin
                                    emit = 1'b1;
                                    res.error_code = ERR_ID;
                                end
                                else
                                begin
                                    phase_next = PH_PASS;
                                    emit = 1'b1;
                                    res.result_kind = RK_SUMMARY;
                                end
                            end
                            else if (mpeg2_mode)
                            begin
                                if (plen_full != 16'd0 && plen_full < 16'd3)
                                begin
                                    emit = 1'b1;
                                    res.error_code = ERR_SHORT;
                                end
                                else
                                    phase_next = PH_M2HDR;
                            end
                            else
                                phase_next = PH_M1STUFF;
                        end
                        if (emit && res.result_kind != RK_SUMMARY)
                        begin
                            res.result_kind = RK_ERROR;
                            res.last_of_packet = 1'b1;
                            done_next = 1'b1;
                        end
                    end

                    PH_M2HDR:
                    begin
                        if (count_reg == 17'd6)
                            flags_next = {1'b0, in_byte[5:0], 6'd0};
                        else if (count_reg == 17'd7)
                        begin
                            flags_next = {flags_reg[12:6], in_byte[5:0]};
                            tsf_next = in_byte[7:6];
                        end
                        else if (count_reg == 17'd8)
                        begin
                            hlen_next = in_byte;
                            if (bounded && ({9'd0, in_byte} + 17'd3 >= {1'b0, plen_reg}))
                            begin
                                emit = 1'b1;
                                res.result_kind = RK_ERROR;
                                res.error_code = ERR_PASTEND;
                                res.last_of_packet = 1'b1;
                                done_next = 1'b1;
                            end
                            else if ({3'd0, need} > in_byte)
                            begin
                                emit = 1'b1;
                                res.result_kind = RK_ERROR;
                                res.error_code = ERR_FLAGS;
                                res.last_of_packet = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                hleft_next = in_byte;
                                if (in_byte == 8'd0)
                                begin
                                    phase_next = PH_M2DATA;
                                    emit = 1'b1;
                                    res.result_kind = RK_SUMMARY;
                                    res.header_flags = flags_reg;
                                    res.header_data_length = in_byte;
                                end
                            end
                        end
                        else
                        begin
                            if (tsf_reg[1] && off < 17'd5)
                                pts_next = {pts_reg[31:0], in_byte};
                            else if (tsf_reg == 2'b11 && off >= 17'd5 && off < 17'd10)
                                dts_next = {dts_reg[31:0], in_byte};
                            hleft_next = hl_dec;
                            if (hl_dec == 8'd0)
                            begin
                                phase_next = PH_M2DATA;
                                emit = 1'b1;
                                res.result_kind = RK_SUMMARY;
                                res.header_flags = flags_reg;
                                res.header_data_length = hlen_reg;
                                sum_p = tsf_reg[1];
                                sum_d = tsf_reg == 2'b11;
                            end
                        end
                    end

                    PH_M1STUFF, PH_M1CODE:
                    begin
                        if (phase_reg == PH_M1STUFF && in_byte == 8'hFF)
                        begin
                            if (last)
                            begin
                                emit = 1'b1;
                                res.error_code = ERR_M1HDR;
                            end
                        end
                        else if (phase_reg == PH_M1STUFF && (in_byte & 8'hC0) == 8'h40)
                        begin
                            if (last)
                            begin
                                emit = 1'b1;
                                res.error_code = ERR_M1HDR;
                            end
                            else
                                phase_next = PH_M1STD;
                        end
                        else if ((in_byte & 8'hF0) == 8'h20 || (in_byte & 8'hF0) == 8'h30)
                        begin
                            if (bounded && rem < ((in_byte[4]) ? 17'd10 : 17'd5))
                            begin
                                emit = 1'b1;
                                res.error_code = ERR_M1HDR;
                            end
                            else
                            begin
                                tsf_next = in_byte[4] ? 2'b11 : 2'b10;
                                pts_next = {32'd0, in_byte};
                                hleft_next = in_byte[4] ? 8'd9 : 8'd4;
                                phase_next = PH_M1TS;
                            end
                        end
                        else if (in_byte == 8'h0F)
                        begin
                            tsf_next = 2'b00;
                            phase_next = PH_M1DATA;
                            emit = 1'b1;
                            res.result_kind = RK_SUMMARY;
                            res.last_of_packet = last;
                            done_next = last;
                        end
                        else
                        begin
                            emit = 1'b1;
                            res.error_code = ERR_TSCODE;
                        end
                        if (emit && res.result_kind != RK_SUMMARY)
                        begin
                            res.result_kind = RK_ERROR;
                            res.last_of_packet = 1'b1;
                            done_next = 1'b1;
                        end
                    end

                    PH_M1STD:
                    begin
                        if (last)
                        begin
                            emit = 1'b1;
                            res.result_kind = RK_ERROR;
                            res.error_code = ERR_M1HDR;
                            res.last_of_packet = 1'b1;
                            done_next = 1'b1;
                        end
                        else
                            phase_next = PH_M1CODE;
                    end

                    PH_M1TS:
                    begin
                        hleft_next = hl_dec;
                        if (tsf_reg[0] && hleft_reg <= 8'd5)
                            dts_next = {dts_reg[31:0], in_byte};
                        else
                            pts_next = {pts_reg[31:0], in_byte};
                        if (hl_dec == 8'd0)
                        begin
                            phase_next = PH_M1DATA;
                            emit = 1'b1;
                            res.result_kind = RK_SUMMARY;
                            res.last_of_packet = last;
                            done_next = last;
                            sum_p = tsf_reg[1];
                            sum_d = tsf_reg == 2'b11;
                        end
                    end

                    default:
                    begin
                        emit = 1'b1;
                        res.result_kind = RK_PAYLOAD;
                        res.data_value = in_byte;
                        res.last_of_packet = last;
                        done_next = last;
                    end
                endcase
            end
        end

        if (sum_p)
        begin
            res.pts_present = 1'b1;
            res.pts_value = ts_of(pts_next);
        end
        if (sum_d)
        begin
            res.dts_present = 1'b1;
            res.dts_value = ts_of(dts_next);
        end
        if (res.result_kind == RK_SUMMARY && phase_reg == PH_M2HDR && !sum_p)
        begin
            res.pts_present = 1'b0;
        end
        res_valid = emit;
    end

endmodule

FILE: rtl/pes_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// PES parser result queue
// Short register queue between the front end and the output side.
// ============================================================================
module pes_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  pes_pkg::result_t    wr_data,
    output logic                full,
    input  logic                rd_en,
    output logic                empty,
    output pes_pkg::result_t    rd_data
);
    import pes_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    result_t          mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

endmodule

FILE: rtl/pes_packet_header_parser_top.sv
`timescale 1ns / 1ps
// ============================================================================
// PES packet header parser
// Parses one PES packet a byte at a time and emits header summary, payload
// and error transactions through a result queue.
// ============================================================================
// Channel   Direction  Handshake        Payload
// input     in         push / full      kind, in_byte
// result    out        pop / empty      result_kind ... last_of_packet
// config    in         APB write/read   mpeg2_mode at address 0
//
// One byte is accepted every cycle while the result queue has room.
// A result is written into the queue as its byte is accepted; the queue depth
// sets how long the output side may stall before full rises.
// Reset clears the phase, the counters and the queue.
// ============================================================================
module pes_packet_header_parser_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [7:0]  in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  result_kind,
    output logic [7:0]  data_value,
    output logic [7:0]  stream_code,
    output logic [32:0] pts_value,
    output logic [32:0] dts_value,
    output logic        pts_present,
    output logic        dts_present,
    output logic [12:0] header_flags,
    output logic [7:0]  header_data_length,
    output logic [3:0]  error_code,
    output logic        last_of_packet
);
    import pes_pkg::*;

    logic    mode_reg;
    logic    res_valid, q_full, acc;
    result_t res, q_out;

    assign pready = 1'b1;
    assign prdata = {31'd0, mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b1;
        else if (psel && penable && pwrite && paddr == 1'b0)
            mode_reg <= pwdata[0];
    end

    assign full = q_full;
    assign acc  = push && !q_full;

    pes_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mpeg2_mode (mode_reg),
        .in_valid   (acc),
        .kind       (kind),
        .in_byte    (in_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    pes_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .full    (q_full),
        .rd_en   (pop && !empty),
        .empty   (empty),
        .rd_data (q_out)
    );

    assign result_kind        = q_out.result_kind;
    assign data_value         = q_out.data_value;
    assign stream_code        = q_out.stream_code;
    assign pts_value          = q_out.pts_value;
    assign dts_value          = q_out.dts_value;
    assign pts_present        = q_out.pts_present;
    assign dts_present        = q_out.dts_present;
    assign header_flags       = q_out.header_flags;
    assign header_data_length = q_out.header_data_length;
    assign error_code         = q_out.error_code;
    assign last_of_packet     = q_out.last_of_packet;

endmodule

FILE: rtl/pes_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// PES parser port checker
// Checks result transactions seen at the top-level ports.
// ============================================================================
module pes_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  result_kind,
    input logic [3:0]  error_code,
    input logic        last_of_packet,
    input logic        pts_present,
    input logic        dts_present
);
    import pes_pkg::*;

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == RK_ERROR) |-> last_of_packet)
        else $error("error transaction without last flag");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind != RK_ERROR) |-> (error_code == ERR_NONE))
        else $error("error code outside an error transaction");

    a_dts: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && dts_present) |-> pts_present)
        else $error("DTS without PTS");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result_kind)))
        else $error("waiting result changed");

endmodule

bind pes_packet_header_parser_top pes_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .result_kind    (result_kind),
    .error_code     (error_code),
    .last_of_packet (last_of_packet),
    .pts_present    (pts_present),
    .dts_present    (dts_present)
);

FILE: test/tb_pes_packet_header_parser_top.sv
`timescale 1ns / 1ps
// ============================================================================
// PES packet header parser testbench
// Sends one unbounded MPEG-2 packet. The header carries a PTS and a DTS with
// every bit set. A long run of random payload bytes follows, and a forced end
// closes the packet. Every result transaction is compared with a local
// predictor of the parser. The mode register is written and read back while
// the block is idle. Both handshakes idle at random, and the result side holds
// off once for long enough to fill the block.
// ============================================================================
module tb_pes_packet_header_parser_top;
    import pes_pkg::*;

    typedef struct {
        bit     k;
        bit [7:0] b;
        int     want_kind;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    logic        full;
    logic        kind = 1'b0;
    logic [7:0]  in_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  data_value;
    logic [7:0]  stream_code;
    logic [32:0] pts_value;
    logic [32:0] dts_value;
    logic        pts_present;
    logic        dts_present;
    logic [12:0] header_flags;
    logic [7:0]  header_data_length;
    logic [3:0]  error_code;
    logic        last_of_packet;

    result_t     pending_results[$];
    int          mismatches = 0;
    bit          hold_off = 1'b0;
    bit          calm = 1'b0;

    bit          p_mode;
    phase_t      p_phase;
    logic [16:0] p_count;
    logic [15:0] p_len;
    logic [7:0]  p_sid;
    logic [12:0] p_flags;
    logic [7:0]  p_hlen;
    logic [7:0]  p_left;
    logic [39:0] p_pts;
    logic [39:0] p_dts;
    bit          p_done;
    logic [1:0]  p_ts;
    int          last_kind;

    always #5 clk = ~clk;

    pes_packet_header_parser_top u_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .kind(kind), .in_byte(in_byte),
        .empty(empty), .pop(pop), .result_kind(result_kind), .data_value(data_value),
        .stream_code(stream_code), .pts_value(pts_value), .dts_value(dts_value),
        .pts_present(pts_present), .dts_present(dts_present),
        .header_flags(header_flags), .header_data_length(header_data_length),
        .error_code(error_code), .last_of_packet(last_of_packet)
    );

    function automatic logic [32:0] stamp_bits(input logic [39:0] s);
        stamp_bits = {s[35:33], s[31:24], s[23:17], s[15:8], s[7:1]};
    endfunction

    function automatic result_t blank_result(input logic [1:0] rk, input logic [7:0] d,
                                             input logic [3:0] err, input bit last);
        result_t r;
        r = '0;
        r.result_kind = rk;
        r.data_value = d;
        r.stream_code = p_sid;
        r.error_code = err;
        r.last_of_packet = last;
        return r;
    endfunction

    task automatic expect_error(input logic [3:0] err);
        pending_results.push_back(blank_result(RK_ERROR, 8'h00, err, 1'b1));
        last_kind = RK_ERROR;
        p_done = 1'b1;
    endtask

    task automatic expect_summary(input bit last);
        result_t r;
        bit      has_pts;
        bit      has_dts;
        has_pts = p_ts[1];
        has_dts = p_ts[1] && p_ts[0];
        r = blank_result(RK_SUMMARY, 8'h00, ERR_NONE, last);
        r.pts_value = has_pts ? stamp_bits(p_pts) : '0;
        r.dts_value = has_dts ? stamp_bits(p_dts) : '0;
        r.pts_present = has_pts;
        r.dts_present = has_dts;
        r.header_flags = p_flags;
        r.header_data_length = p_hlen;
        pending_results.push_back(r);
        last_kind = RK_SUMMARY;
        if (last)
            p_done = 1'b1;
    endtask

    task automatic timestamp_code(input logic [7:0] b, input int cnt, input bit bounded,
                                  input bit last);
        int rem;
        bit both;
        rem = bounded ? (6 + int'(p_len)) - cnt : 32'hFFFFFF;
        both = (b[7:4] == 4'h3);
        if (b[7:4] == 4'h2 || both) begin
            if (rem < (both ? 10 : 5))
                expect_error(ERR_M1HDR);
            else begin
                p_ts = both ? 2'd3 : 2'd2;
                p_pts = {32'h0, b};
                p_left = both ? 8'd9 : 8'd4;
                p_phase = PH_M1TS;
            end
        end
        else if (b == 8'h0F) begin
            p_ts = 2'd0;
            p_phase = PH_M1DATA;
            expect_summary(last);
        end
        else
            expect_error(ERR_TSCODE);
    endtask

    task automatic parse_byte(input bit k, input logic [7:0] b);
        int  cnt;
        int  need;
        int  off;
        int  hl;
        bit  bounded;
        bit  last;
        last_kind = -1;
        if (p_done)
            return;
        bounded = (p_len != 0);
        if (k) begin
            if (p_phase == PH_PREFIX)
                expect_error(ERR_SHORT);
            else if (bounded)
                expect_error(ERR_LENGTH);
            else
                case (p_phase)
                    PH_PASS, PH_M1DATA: expect_error(ERR_NONE);
                    PH_M2HDR: expect_error(p_count < 9 ? ERR_SHORT : ERR_PASTEND);
                    PH_M2DATA: expect_error(int'(p_count) == 9 + int'(p_hlen) ?
                                            ERR_PASTEND : ERR_NONE);
                    default: expect_error(ERR_M1HDR);
                endcase
            return;
        end
        cnt = p_count;
        if (p_count < COUNT_MAX)
            p_count = p_count + 1'b1;
        last = (p_phase != PH_PREFIX) && bounded && (int'(p_count) == 6 + int'(p_len));
        case (p_phase)
            PH_PREFIX: begin
                if (cnt < 2) begin
                    if (b != 8'h00)
                        expect_error(ERR_START);
                end
                else if (cnt == 2) begin
                    if (b != 8'h01)
                        expect_error(ERR_START);
                end
                else if (cnt == 3)
                    p_sid = b;
                else if (cnt == 4)
                    p_len = {b, 8'h00};
                else begin
                    p_len[7:0] = b;
                    if (p_sid inside {8'hBE, 8'hBF, 8'hBC, 8'hF0, 8'hF1, 8'hF2, 8'hF8,
                                      8'hFF}) begin
                        if (!p_mode && p_sid != 8'hBF && p_sid != 8'hBE)
                            expect_error(ERR_ID);
                        else begin
                            p_phase = PH_PASS;
                            expect_summary(1'b0);
                        end
                    end
                    else if (p_mode) begin
                        if (p_len != 0 && p_len < 3)
                            expect_error(ERR_SHORT);
                        else
                            p_phase = PH_M2HDR;
                    end
                    else
                        p_phase = PH_M1STUFF;
                end
            end
            PH_M2HDR: begin
                if (cnt == 6)
                    p_flags = {1'b0, b[5:0], 6'h00};
                else if (cnt == 7) begin
                    p_flags[5:0] = b[5:0];
                    p_ts = b[7:6];
                end
                else if (cnt == 8) begin
                    need = 0;
                    p_hlen = b;
                    if (p_ts[1])
                        need = p_ts[0] ? 10 : 5;
                    if (!p_flags[0])
                        need += (p_flags[5] ? 6 : 0) + (p_flags[4] ? 3 : 0)
                              + (p_flags[3] ? 1 : 0) + (p_flags[2] ? 1 : 0)
                              + (p_flags[1] ? 2 : 0);
                    if (bounded && int'(b) + 3 >= int'(p_len))
                        expect_error(ERR_PASTEND);
                    else if (need > int'(b))
                        expect_error(ERR_FLAGS);
                    else begin
                        p_left = b;
                        if (b == 0) begin
                            p_phase = PH_M2DATA;
                            expect_summary(1'b0);
                        end
                    end
                end
                else begin
                    off = cnt - 9;
                    if (p_ts[1] && off < 5)
                        p_pts = {p_pts[31:0], b};
                    else if (p_ts == 2'd3 && off >= 5 && off < 10)
                        p_dts = {p_dts[31:0], b};
                    p_left = p_left - 1'b1;
                    if (p_left == 0) begin
                        p_phase = PH_M2DATA;
                        expect_summary(1'b0);
                    end
                end
            end
            PH_M1STUFF: begin
                if (b == 8'hFF) begin
                    if (last)
                        expect_error(ERR_M1HDR);
                end
                else if (b[7:6] == 2'b01) begin
                    if (last)
                        expect_error(ERR_M1HDR);
                    else
                        p_phase = PH_M1STD;
                end
                else
                    timestamp_code(b, cnt, bounded, last);
            end
            PH_M1STD: begin
                if (last)
                    expect_error(ERR_M1HDR);
                else
                    p_phase = PH_M1CODE;
            end
            PH_M1CODE: timestamp_code(b, cnt, bounded, last);
            PH_M1TS: begin
                hl = p_left;
                p_left = p_left - 1'b1;
                if (p_ts[0] && hl <= 5)
                    p_dts = {p_dts[31:0], b};
                else
                    p_pts = {p_pts[31:0], b};
                if (p_left == 0) begin
                    p_phase = PH_M1DATA;
                    expect_summary(last);
                end
            end
            default: begin
                pending_results.push_back(blank_result(RK_PAYLOAD, b, ERR_NONE, last));
                last_kind = RK_PAYLOAD;
                if (last)
                    p_done = 1'b1;
            end
        endcase
    endtask

    task automatic send_byte(input bit k, input logic [7:0] b, input bit may_idle);
        push <= 1'b1;
        kind <= k;
        in_byte <= b;
        do
            @(posedge clk);
        while (full);
        parse_byte(k, b);
        if (may_idle && !calm && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic drain;
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_mode(input bit v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {31'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        p_mode = v;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[0] !== v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mode read-back mismatch: expected %0d, got %0h", v, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk) begin
        result_t got;
        result_t want;
        if (rst_n && pop && !empty) begin
            got = {result_kind, data_value, stream_code, pts_value, dts_value, pts_present,
                   dts_present, header_flags, header_data_length, error_code,
                   last_of_packet};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: %h", got);
            end
            else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result mismatch: expected %h, got %h", want, got);
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            if (hold_off) begin
                pop <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    initial begin
        #5_000_000;
        $display("pes_packet_header_parser_top test failed");
        $finish;
    end

    initial begin
        stim_row_t header_rows[$];
        int        i;
        header_rows = '{
            '{0, 8'h00, -1}, '{0, 8'h00, -1}, '{0, 8'h01, -1}, '{0, 8'hE0, -1},
            '{0, 8'h00, -1}, '{0, 8'h00, -1}, '{0, 8'hBF, -1}, '{0, 8'hC0, -1},
            '{0, 8'h0A, -1},
            '{0, 8'h3F, -1}, '{0, 8'hFF, -1}, '{0, 8'hFF, -1}, '{0, 8'hFF, -1},
            '{0, 8'hFF, -1}, '{0, 8'h1F, -1}, '{0, 8'hFF, -1}, '{0, 8'hFF, -1},
            '{0, 8'hFF, -1}, '{0, 8'hFF, RK_SUMMARY},
            '{0, 8'h00, RK_PAYLOAD}, '{0, 8'hFF, RK_PAYLOAD},
            '{0, 8'h55, RK_PAYLOAD}, '{0, 8'hAA, RK_PAYLOAD}
        };
        p_mode = 1'b1;
        p_phase = PH_PREFIX;
        p_count = '0;
        p_len = '0;
        p_sid = '0;
        p_flags = '0;
        p_hlen = '0;
        p_left = '0;
        p_pts = '0;
        p_dts = '0;
        p_done = 1'b0;
        p_ts = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b0);
        write_mode(1'b1);
        write_mode(1'b0);
        write_mode(1'b1);
        foreach (header_rows[i]) begin
            send_byte(header_rows[i].k, header_rows[i].b, 1'b1);
            if (header_rows[i].want_kind >= 0 && last_kind != header_rows[i].want_kind) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Header row %0d: expected kind %0d, predicted %0d",
                             i, header_rows[i].want_kind, last_kind);
            end
        end
        if (!(stamp_bits(p_pts) == 33'h1FFFFFFFF && stamp_bits(p_dts) == 33'h1FFFFFFFF)) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Timestamps not all ones after header: expected %h %h, got %h %h",
                         33'h1FFFFFFFF, 33'h1FFFFFFFF, stamp_bits(p_pts), stamp_bits(p_dts));
        end
        for (i = 0; i < 1200; i++) begin
            if (i == 200)
                hold_off = 1'b1;
            if (i == 400 || i == 800) begin
                drain();
                write_mode(i == 400 ? 1'b0 : 1'b1);
            end
            if (i == 1050)
                calm = 1'b1;
            send_byte(1'b0, 8'($urandom), 1'b1);
        end
        send_byte(1'b1, 8'h00, 1'b0);
        for (i = 0; i < 8; i++)
            send_byte(i[0], 8'($urandom), 1'b0);
        drain();
        if (mismatches == 0)
            $display("pes_packet_header_parser_top test passed");
        else
            $display("pes_packet_header_parser_top test failed");
        $finish;
    end

endmodule
